>>> hw/rtl/ptw_pkg.sv
package ptw_pkg;

   localparam int WHEEL_SLOTS = 8;
   localparam int MAX_TIMERS  = 16;
   localparam int PERIOD_BITS = 16;
   localparam int ID_BITS     = 4;
   localparam int SLOT_BITS   = $clog2(WHEEL_SLOTS);
   localparam int ROUND_BITS  = PERIOD_BITS - SLOT_BITS;

   typedef enum logic [1:0] {
      FUNC_REG   = 2'd0,
      FUNC_UNREG = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_REG    = 2'd0,
      KIND_UNREG  = 2'd1,
      KIND_EXPIRE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO_PER = 2'd1,
      STAT_NO_ID    = 2'd2
   } status_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                   wr_en;
      logic                   unreg_en;
      logic [ID_BITS-1:0]     id;
      logic [PERIOD_BITS-1:0] period;
      logic [SLOT_BITS-1:0]   cur_slot;
   } cmd_type;

   typedef struct packed {
      logic fire;   // token here, entry in current slot, no rounds left
      logic live;   // entry is valid and matches cmd.id
   } cell_stat_type;

   // wheel size is a power of two, so the slot wraps by truncation
   function automatic logic [SLOT_BITS-1:0] arm_slot(
      input logic [SLOT_BITS-1:0]   cur,
      input logic [PERIOD_BITS-1:0] period
   );
      logic [SLOT_BITS-1:0] sum;
      sum = cur + period[SLOT_BITS-1:0];
      return sum;
   endfunction

   function automatic logic [ROUND_BITS-1:0] arm_rounds(
      input logic [PERIOD_BITS-1:0] period
   );
      logic [PERIOD_BITS-1:0] pm1;
      pm1 = period - PERIOD_BITS'(1);
      return pm1[PERIOD_BITS-1:SLOT_BITS];
   endfunction

endpackage

>>> hw/rtl/ptw_cell.sv
module ptw_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ptw_pkg::ID_BITS-1:0]  cell_id,
   input  ptw_pkg::cmd_type             cmd,
   input  logic                         token_in,
   input  logic                         step,
   output logic                         token_out,
   output ptw_pkg::cell_stat_type       stat
);

   logic                              valid_ff, valid_in;
   logic                              token_ff, token_in_nx;
   logic [ptw_pkg::PERIOD_BITS-1:0]   period_ff, period_in;
   logic [ptw_pkg::SLOT_BITS-1:0]     slot_ff, slot_in;
   logic [ptw_pkg::ROUND_BITS-1:0]    rounds_ff, rounds_in;
   logic                              hit;
   logic                              fire;
   logic                              id_match;

   always_comb begin
      id_match = (cmd.id == cell_id);
      hit      = token_ff && valid_ff && (slot_ff == cmd.cur_slot);
      fire     = hit && (rounds_ff == '0);

      valid_in    = valid_ff;
      period_in   = period_ff;
      slot_in     = slot_ff;
      rounds_in   = rounds_ff;
      token_in_nx = step ? token_in : token_ff;

      if (cmd.wr_en && id_match) begin
         valid_in  = 1'b1;
         period_in = cmd.period;
         slot_in   = ptw_pkg::arm_slot(cmd.cur_slot, cmd.period);
         rounds_in = ptw_pkg::arm_rounds(cmd.period);
      end else if (cmd.unreg_en && id_match) begin
         valid_in = 1'b0;
      end else if (hit && step) begin
         if (fire) begin
            // re-arm one full period ahead
            slot_in   = ptw_pkg::arm_slot(cmd.cur_slot, period_ff);
            rounds_in = ptw_pkg::arm_rounds(period_ff);
         end else begin
            rounds_in = rounds_ff - ptw_pkg::ROUND_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         token_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         token_ff <= token_in_nx;
      end
      period_ff <= period_in;
      slot_ff   <= slot_in;
      rounds_ff <= rounds_in;
   end

   assign token_out = token_ff;
   assign stat.fire = fire;
   assign stat.live = valid_ff && id_match;

endmodule

>>> hw/rtl/periodic_timing_wheel.sv
// Register / unregister: status item in the output register the cycle after acceptance.
// Tick: a scan token walks the chain of MAX_TIMERS cells one cell per cycle, held while
// a second expiry waits on a full output register; the next item is taken once the scan
// has drained. One item at a time; the wheel holds 16 timers.
// Reset (synchronous, active high) clears all timers, the current slot and the output
// register; no clearing pass, the block is ready as soon as reset drops.
module periodic_timing_wheel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [3:0] timer_id, [19:4] period, [23:20] zero
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] timer_id_res, [5:4] status, [7:6] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type                        state_ff, state_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ptw_pkg::kind_type                rsp_kind_ff, rsp_kind_in;
   logic [ptw_pkg::ID_BITS-1:0]      rsp_id_ff, rsp_id_in;
   ptw_pkg::status_type              rsp_stat_ff, rsp_stat_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [ptw_pkg::ID_BITS-1:0]      pend_id_ff, pend_id_in;
   logic [ptw_pkg::SLOT_BITS-1:0]    cur_ff, cur_in;

   logic [ptw_pkg::ID_BITS-1:0]      req_id;
   logic [ptw_pkg::PERIOD_BITS-1:0]  req_period;
   logic                             req_acc;
   logic                             out_free;
   logic                             id_ok;
   logic                             start;
   logic                             step;
   logic                             any_fire;
   logic                             any_live;
   logic                             scan_done;
   logic [ptw_pkg::ID_BITS-1:0]      fire_id;
   logic [ptw_pkg::MAX_TIMERS-1:0]   token_vec;
   logic [ptw_pkg::MAX_TIMERS-1:0]   fire_vec;
   logic [ptw_pkg::MAX_TIMERS-1:0]   live_vec;
   ptw_pkg::cmd_type                 cmd;
   ptw_pkg::cell_stat_type           stat_vec [ptw_pkg::MAX_TIMERS];

   assign req_id     = req_tdata[ptw_pkg::ID_BITS-1:0];
   assign req_period = req_tdata[ptw_pkg::ID_BITS +: ptw_pkg::PERIOD_BITS];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign id_ok      = (32'(req_id) < ptw_pkg::MAX_TIMERS);
   assign start      = req_acc && (req_tuser == ptw_pkg::FUNC_TICK);

   assign cmd.wr_en    = req_acc && (req_tuser == ptw_pkg::FUNC_REG) && id_ok
                         && (req_period != '0);
   assign cmd.unreg_en = req_acc && (req_tuser == ptw_pkg::FUNC_UNREG) && id_ok;
   assign cmd.id       = req_id;
   assign cmd.period   = req_period;
   assign cmd.cur_slot = cur_ff;

   genvar gi;
   generate
      for (gi = 0; gi < ptw_pkg::MAX_TIMERS; gi++) begin : g_cell
         logic tok_prev;
         if (gi == 0) begin : g_head
            assign tok_prev = start;
         end else begin : g_body
            assign tok_prev = token_vec[gi-1];
         end
         ptw_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cell_id   (ptw_pkg::ID_BITS'(gi)),
            .cmd       (cmd),
            .token_in  (tok_prev),
            .step      (step),
            .token_out (token_vec[gi]),
            .stat      (stat_vec[gi])
         );
         assign fire_vec[gi] = stat_vec[gi].fire;
         assign live_vec[gi] = stat_vec[gi].live;
      end
   endgenerate

   always_comb begin
      fire_id = '0;
      for (int i = 0; i < ptw_pkg::MAX_TIMERS; i++) begin
         if (fire_vec[i]) fire_id = ptw_pkg::ID_BITS'(i);
      end
   end

   assign any_fire  = |fire_vec;
   assign any_live  = |live_vec;
   // hold the token while a second expiry waits on a full output register
   assign step      = !(any_fire && pend_valid_ff && !out_free);
   assign scan_done = token_vec[ptw_pkg::MAX_TIMERS-1] && step;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_stat_in   = rsp_stat_ff;
      rsp_last_in   = rsp_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      cur_in        = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_tuser)
                  ptw_pkg::FUNC_REG: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ptw_pkg::KIND_REG;
                     rsp_id_in    = req_id;
                     rsp_last_in  = 1'b1;
                     if (!id_ok)                 rsp_stat_in = ptw_pkg::STAT_NO_ID;
                     else if (req_period == '0)  rsp_stat_in = ptw_pkg::STAT_ZERO_PER;
                     else                        rsp_stat_in = ptw_pkg::STAT_OK;
                  end
                  ptw_pkg::FUNC_UNREG: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ptw_pkg::KIND_UNREG;
                     rsp_id_in    = req_id;
                     rsp_last_in  = 1'b1;
                     rsp_stat_in  = (id_ok && any_live) ? ptw_pkg::STAT_OK
                                                        : ptw_pkg::STAT_NO_ID;
                  end
                  ptw_pkg::FUNC_TICK: begin
                     cur_in   = (32'(cur_ff) == ptw_pkg::WHEEL_SLOTS - 1) ? '0
                                : cur_ff + ptw_pkg::SLOT_BITS'(1);
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // one expiry is held back until the next one or the end of the scan
            if (step && any_fire) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = ptw_pkg::KIND_EXPIRE;
                  rsp_id_in    = pend_id_ff;
                  rsp_stat_in  = ptw_pkg::STAT_OK;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_id_in    = fire_id;
            end
            if (scan_done) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ptw_pkg::KIND_EXPIRE;
               rsp_id_in     = pend_id_ff;
               rsp_stat_in   = ptw_pkg::STAT_OK;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         cur_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         cur_ff        <= cur_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
      pend_id_ff  <= pend_id_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_stat_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_token_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one scan token in the chain");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (token_vec == '0))
      else $error("scan token left over while idle");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held expiry while idle");

   a_tick_scans: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_SCAN) && token_vec[0])
      else $error("tick did not start a scan");

   a_fire_only_scan: assert property (@(posedge clock) disable iff (reset)
      any_fire |-> (state_ff == ST_SCAN))
      else $error("expiry outside a scan");

endmodule
